@@ hdl/traw_pkg.sv @@
// Shared types and constants for the taxonomy rank ancestor walk.
// Holds the request and result structs, the queue entry and the codes.
// No dependencies.
`default_nettype none

package traw_pkg;

	localparam int ID_W      = 25;
	localparam int RANK_W    = 3;
	localparam int OUT_RANKS = 6;
	localparam int LIMIT_W   = 8;
	localparam int MASK_W    = OUT_RANKS;

	localparam int ID_BITS_DEFAULT    = 25;
	localparam int RANK_COUNT_DEFAULT = 6;
	localparam int Q_DEPTH            = 2;

	localparam logic [LIMIT_W-1:0] LIMIT_RESET = 8'd64;

	// command field codes
	localparam logic CMD_LOAD  = 1'b0;
	localparam logic CMD_QUERY = 1'b1;

	// queue entry kinds, set by the front end
	localparam int KIND_W = 2;
	localparam logic [KIND_W-1:0] JOB_LOAD = 2'd0;
	localparam logic [KIND_W-1:0] JOB_WALK = 2'd1;
	localparam logic [KIND_W-1:0] JOB_NULL = 2'd2;

	typedef struct packed {
		logic              cmd;
		logic [ID_W-1:0]   node_id;
		logic [ID_W-1:0]   parent_id;
		logic [RANK_W-1:0] rank_level;
	} in_item_t;

	typedef struct packed {
		logic [ID_W-1:0]   query_echo;
		logic [ID_W-1:0]   species_ancestor;
		logic [ID_W-1:0]   genus_ancestor;
		logic [ID_W-1:0]   family_ancestor;
		logic [ID_W-1:0]   order_ancestor;
		logic [ID_W-1:0]   class_ancestor;
		logic [ID_W-1:0]   phylum_ancestor;
		logic [MASK_W-1:0] found_mask;
		logic              walk_cut;
	} out_item_t;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		in_item_t          item;
	} job_t;

endpackage

`default_nettype wire

@@ hdl/traw_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module traw_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

@@ hdl/traw_front.sv @@
// Front end: register each incoming request and classify it as load,
// walk or empty query before it enters the queue. Depends on traw_pkg.
`default_nettype none

module traw_front #(
	parameter int ID_BITS = 25
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire traw_pkg::in_item_t in_item,
	output logic                   push,
	output traw_pkg::job_t         push_job,
	input  wire logic              q_full
);

	import traw_pkg::*;

	logic              valid_s1;
	job_t              job_s1;
	logic [KIND_W-1:0] kind;

	// query of id zero is answered without a table read
	always_comb begin
		priority if (in_item.cmd == CMD_LOAD) begin
			kind = JOB_LOAD;
		end else if (ID_BITS'(in_item.node_id) == '0) begin
			kind = JOB_NULL;
		end else begin
			kind = JOB_WALK;
		end
	end

	assign in_stall = valid_s1 && q_full;
	assign push     = valid_s1 && !q_full;
	assign push_job = job_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			job_s1.kind <= kind;
			job_s1.item <= in_item;
		end
	end

endmodule

`default_nettype wire

@@ hdl/traw_queue.sv @@
// Short FIFO between the front end and the walk engine.
// Depends on traw_pkg for the entry type and depth.
`default_nettype none

module traw_queue (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	input  wire traw_pkg::job_t push_job,
	output logic               full,
	input  wire logic          pop,
	output traw_pkg::job_t     pop_job,
	output logic               empty
);

	import traw_pkg::*;

	localparam int PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
	localparam int CNT_W = $clog2(Q_DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST = PTR_W'(Q_DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(Q_DEPTH);

	job_t             slot_q [Q_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == FULL_CNT);
	assign empty   = (count_q == '0);
	assign pop_job = slot_q[rd_ptr_q];
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_job;
		end
	end

endmodule

`default_nettype wire

@@ hdl/traw_back.sv @@
// Walk engine: owns the node table, applies loads, walks parent links for
// queries and holds the result register. Depends on traw_pkg and traw_ram.
`default_nettype none

module traw_back #(
	parameter int ID_BITS    = 25,
	parameter int RANK_COUNT = 6
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire traw_pkg::job_t                 job,
	input  wire logic                           job_valid,
	output logic                                pop,
	input  wire logic [traw_pkg::LIMIT_W-1:0]   walk_limit,
	output logic                                out_valid,
	input  wire logic                           out_stall,
	output traw_pkg::out_item_t                 out_item
);

	import traw_pkg::*;

	localparam int RANK_USED = (RANK_COUNT < OUT_RANKS) ? RANK_COUNT : OUT_RANKS;
	localparam int ENTRY_W   = ID_BITS + RANK_W;
	localparam int DEPTH     = 2 ** ID_BITS;
	localparam logic [ID_BITS-1:0] ROOT_ID = ID_BITS'(1);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_WALK = 1'b1;

	logic                state_q;
	logic [ID_BITS-1:0]  cur_q;
	logic [LIMIT_W-1:0]  steps_q;
	logic [ID_BITS-1:0]  echo_q;
	logic [ID_BITS-1:0]  anc_q [OUT_RANKS];
	logic [MASK_W-1:0]   mask_q;
	logic                res_valid_q;
	out_item_t           res_q;

	logic [ID_BITS-1:0]  job_id;
	logic [ENTRY_W-1:0]  rd_data;
	logic [ID_BITS-1:0]  par;
	logic [RANK_W-1:0]   rk;
	logic                end_root;
	logic                cut;
	logic                done;
	logic                rec;
	logic [ID_BITS-1:0]  anc_n [OUT_RANKS];
	logic [MASK_W-1:0]   mask_n;
	logic                out_free;
	logic                we;
	logic                re;
	logic [ID_BITS-1:0]  raddr;
	logic                start_walk;
	logic                finish;
	logic                emit_null;
	out_item_t           res_d;

	assign job_id   = ID_BITS'(job.item.node_id);
	assign par      = rd_data[ENTRY_W-1:RANK_W];
	assign rk       = rd_data[RANK_W-1:0];
	assign out_free = !res_valid_q || !out_stall;

	// evaluate the node whose table entry was read most recently
	assign end_root = (cur_q == ROOT_ID) || (par == ROOT_ID);
	assign cut      = !end_root && (steps_q >= walk_limit);
	assign done     = end_root || cut;
	assign rec      = !end_root && (rk < RANK_W'(RANK_USED)) && !mask_q[rk];

	always_comb begin
		mask_n = mask_q;
		for (int r = 0; r < OUT_RANKS; r++) begin
			anc_n[r] = anc_q[r];
			if (rec && (rk == RANK_W'(r))) begin
				anc_n[r]  = cur_q;
				mask_n[r] = 1'b1;
			end
		end
	end

	assign we         = (state_q == ST_IDLE) && job_valid && (job.kind == JOB_LOAD);
	assign start_walk = (state_q == ST_IDLE) && job_valid && (job.kind == JOB_WALK);
	assign emit_null  = (state_q == ST_IDLE) && job_valid && (job.kind == JOB_NULL) && out_free;
	assign finish     = (state_q == ST_WALK) && done && out_free;
	assign re         = start_walk || ((state_q == ST_WALK) && !done);
	assign raddr      = (state_q == ST_IDLE) ? job_id : par;
	assign pop        = we || start_walk || emit_null;

	always_comb begin
		res_d = '0;
		if (finish) begin
			res_d.query_echo       = ID_W'(echo_q);
			res_d.species_ancestor = ID_W'(anc_n[0]);
			res_d.genus_ancestor   = ID_W'(anc_n[1]);
			res_d.family_ancestor  = ID_W'(anc_n[2]);
			res_d.order_ancestor   = ID_W'(anc_n[3]);
			res_d.class_ancestor   = ID_W'(anc_n[4]);
			res_d.phylum_ancestor  = ID_W'(anc_n[5]);
			res_d.found_mask       = mask_n;
			res_d.walk_cut         = cut;
		end
	end

	traw_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(DEPTH)
	) u_table (
		.clk  (clk),
		.we   (we),
		.waddr(job_id),
		.wdata({ID_BITS'(job.item.parent_id), job.item.rank_level}),
		.re   (re),
		.raddr(raddr),
		.rdata(rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			res_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (start_walk) begin
						state_q <= ST_WALK;
					end
				end
				ST_WALK: begin
					if (finish) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if (finish || emit_null) begin
				res_valid_q <= 1'b1;
			end else if (!out_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start_walk) begin
			cur_q   <= job_id;
			echo_q  <= job_id;
			steps_q <= '0;
			mask_q  <= '0;
			for (int r = 0; r < OUT_RANKS; r++) begin
				anc_q[r] <= '0;
			end
		end else if ((state_q == ST_WALK) && !done) begin
			cur_q   <= par;
			steps_q <= steps_q + 1'b1;
			mask_q  <= mask_n;
			for (int r = 0; r < OUT_RANKS; r++) begin
				anc_q[r] <= anc_n[r];
			end
		end
		if (finish || emit_null) begin
			res_q <= res_d;
		end
	end

	assign out_valid = res_valid_q;
	assign out_item  = res_q;

endmodule

`default_nettype wire

@@ hdl/taxonomy_rank_ancestor_walk_top.sv @@
// Top level of the taxonomy rank ancestor walk: front end, request queue
// and walk engine. Depends on traw_pkg, traw_front, traw_queue, traw_back.
`default_nettype none

//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+--------------------------
//  in      | input     | in_valid / in_stall  | in_item  (traw_pkg::in_item_t)
//  out     | output    | out_valid / out_stall| out_item (traw_pkg::out_item_t)
//  cfg     | input     | cfg_valid / cfg_ready| cfg_data (walk_limit, 8 bits)
//
//  A load request is written to the node table while the walk engine is
//  idle. A query takes one table read per parent step, one step per cycle
//  through the single read port of the node table, for at most walk_limit
//  parent moves; an id-zero query needs no table read. Requests pass the
//  front register and the queue; the engine pops none while it walks.
//  Reset clears control state and sets walk_limit to 64; the node table is
//  not cleared and needs no clearing pass. A stalled result holds in the
//  output register while the front end keeps filling the queue.

module taxonomy_rank_ancestor_walk_top #(
	parameter int ID_BITS    = traw_pkg::ID_BITS_DEFAULT,
	parameter int RANK_COUNT = traw_pkg::RANK_COUNT_DEFAULT
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         in_valid,
	output logic                              in_stall,
	input  wire traw_pkg::in_item_t           in_item,
	output logic                              out_valid,
	input  wire logic                         out_stall,
	output traw_pkg::out_item_t               out_item,
	input  wire logic                         cfg_valid,
	output logic                              cfg_ready,
	input  wire logic [traw_pkg::LIMIT_W-1:0] cfg_data
);

	import traw_pkg::*;

	logic [LIMIT_W-1:0] walk_limit_q;
	logic               push;
	job_t               push_job;
	logic               q_full;
	logic               q_empty;
	logic               pop;
	job_t               pop_job;

	// the user must write config only while idle; the block does not enforce it and always takes the write
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			walk_limit_q <= LIMIT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			walk_limit_q <= cfg_data;
		end
	end

	// register and classify each request
	traw_front #(
		.ID_BITS(ID_BITS)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_item (in_item),
		.push    (push),
		.push_job(push_job),
		.q_full  (q_full)
	);

	// decouple the front end from the walk engine
	traw_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.push_job(push_job),
		.full    (q_full),
		.pop     (pop),
		.pop_job (pop_job),
		.empty   (q_empty)
	);

	// apply loads in order and walk queries one parent step per cycle
	traw_back #(
		.ID_BITS   (ID_BITS),
		.RANK_COUNT(RANK_COUNT)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job       (pop_job),
		.job_valid (!q_empty),
		.pop       (pop),
		.walk_limit(walk_limit_q),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_item  (out_item)
	);

	// an empty rank always reads zero
	a_unset_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |->
			(out_item.found_mask[0] || out_item.species_ancestor == '0) &&
			(out_item.found_mask[1] || out_item.genus_ancestor == '0) &&
			(out_item.found_mask[2] || out_item.family_ancestor == '0) &&
			(out_item.found_mask[3] || out_item.order_ancestor == '0) &&
			(out_item.found_mask[4] || out_item.class_ancestor == '0) &&
			(out_item.found_mask[5] || out_item.phylum_ancestor == '0))
		else $error("unfound rank carries a nonzero ancestor");

	// an id-zero query never walks, so it can never be cut
	a_zero_not_cut: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.query_echo == '0 |->
			!out_item.walk_cut && out_item.found_mask == '0)
		else $error("id-zero query produced a walk result");

	// a query that starts at the root ends at once
	a_root_empty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.query_echo == ID_W'(1) |->
			!out_item.walk_cut && out_item.found_mask == '0)
		else $error("root query recorded ranks or was cut");

	// the queue never pops while empty
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !q_empty)
		else $error("walk engine popped an empty queue");

endmodule

`default_nettype wire
